@@ src/iparc_pkg.sv @@
// Shared types, codes and a checksum helper for the IPv4 address rewrite block.
package iparc_pkg;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_ENCAP = 2'd1,
        OP_DECAP = 2'd2,
        OP_SWAP  = 2'd3
    } t_op;

    localparam logic [15:0] WORD_MASK = 16'hffff;

    // which header words the chosen mode writes
    typedef struct packed {
        logic src;
        logic dst;
        logic id;
        logic fr;
    } t_word_en;

    // control that travels with a word through the checksum pipe
    typedef struct packed {
        logic valid;
        logic did;
    } t_csum_ctl;

    // one RFC 1624 term: ~m + m' for a written word, else nothing
    function automatic logic [16:0] csum_term(input logic en, input logic [15:0] old_w,
                                              input logic [15:0] new_w);
        logic [16:0] t;
        t = {1'b0, ~old_w & WORD_MASK} + {1'b0, new_w};
        return en ? t : 17'd0;
    endfunction

endpackage

@@ src/iparc_csum.sv @@
// Three-stage incremental checksum pipe: term sums, first fold, second fold and complement (old checksum if unchanged).
module iparc_csum import iparc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_csum_ctl   i_ctl,
    input  t_word_en    i_en,
    input  logic [31:0] i_old_src,
    input  logic [31:0] i_new_src,
    input  logic [31:0] i_old_dst,
    input  logic [31:0] i_new_dst,
    input  logic [15:0] i_old_id,
    input  logic [15:0] i_new_id,
    input  logic [15:0] i_old_fr,
    input  logic [15:0] i_new_fr,
    input  logic [15:0] i_csum,
    output logic        o_valid,
    output logic [15:0] o_checksum
);

    t_csum_ctl   r2_ctl, r3_ctl, r4_ctl;
    logic [19:0] r2_sa, r2_sb;
    logic [15:0] r2_csum, r3_csum;
    logic [16:0] r3_fold;
    logic [15:0] r4_sum;

    logic [19:0] n2_sa, n2_sb, n3_total;
    logic [16:0] n3_fold;
    logic [15:0] n4_f2, n4_sum;

    always_comb begin
        n2_sa = {4'd0, ~i_csum}
              + {3'd0, csum_term(i_en.src, i_old_src[31:16], i_new_src[31:16])}
              + {3'd0, csum_term(i_en.src, i_old_src[15:0],  i_new_src[15:0])}
              + {3'd0, csum_term(i_en.dst, i_old_dst[31:16], i_new_dst[31:16])};
        n2_sb = {3'd0, csum_term(i_en.dst, i_old_dst[15:0], i_new_dst[15:0])}
              + {3'd0, csum_term(i_en.id,  i_old_id,        i_new_id)}
              + {3'd0, csum_term(i_en.fr,  i_old_fr,        i_new_fr)};
        n3_total = r2_sa + r2_sb;
        n3_fold  = {1'b0, n3_total[15:0]} + {13'd0, n3_total[19:16]};
        // after one fold the carry is a single bit and the low part is small
        n4_f2    = r3_fold[15:0] + {15'd0, r3_fold[16]};
        n4_sum   = r3_ctl.did ? ~n4_f2 : r3_csum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
        end else begin
            r2_ctl <= i_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_sa   <= n2_sa;
        r2_sb   <= n2_sb;
        r2_csum <= i_csum;
        r3_fold <= n3_fold;
        r3_csum <= r2_csum;
        r4_sum  <= n4_sum;
    end

    assign o_valid    = r4_ctl.valid;
    assign o_checksum = r4_sum;

    a_valid_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(i_ctl.valid, 3))
        else $error("checksum pipe valid lost or invented");
    a_nodid_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r4_ctl.did) |-> (o_checksum == $past(i_csum, 3)))
        else $error("unchanged header altered its checksum");
    a_fold_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_ctl.valid && r3_fold[16]) |-> (r3_fold[15:0] < 16'h0010))
        else $error("first fold left a wide remainder");

endmodule

@@ src/ipv4_address_rewrite_checksum.sv @@
// Top level: IPv4 address rewrite with RFC 1624 incremental checksum update.
// Path: an accepted word is registered in the decode stage, then in the three checksum
//   pipe stages, and is on the result ports for one cycle.
// Throughput: one word per cycle; the decode stage plus the three-stage checksum
//   pipe are fully pipelined and busy stays low outside reset.
// Reset: synchronous, active low; clears the valid bits, payload is not reset.
// The receiver cannot stall: o_valid marks each result for exactly one cycle.
module ipv4_address_rewrite_checksum import iparc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic        i_override_frag,
    input  logic [31:0] i_target_addr,
    input  logic [7:0]  i_ttl_limit,
    input  logic [31:0] i_entry_mask,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_ident,
    input  logic [15:0] i_frag_word,
    input  logic [7:0]  i_ttl,
    input  logic [15:0] i_hdr_checksum,
    output logic        o_valid,
    output logic [31:0] o_new_src_addr,
    output logic [31:0] o_new_dst_addr,
    output logic [15:0] o_new_ident,
    output logic [15:0] o_new_frag_word,
    output logic [15:0] o_new_checksum,
    output logic        o_changed
);

    // rewritten header fields that ride along the checksum pipe
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] id;
        logic [15:0] fr;
        logic        did;
    } t_pay;

    logic accept;

    // stage 1: mode decode
    logic        r1_valid;
    t_pay        r1_pay;
    t_word_en    r1_en;
    logic [31:0] r1_old_src, r1_old_dst;
    logic [15:0] r1_old_id, r1_old_fr, r1_csum;

    t_pay        n1_pay;
    t_word_en    n1_en;
    logic [15:0] mswap;
    logic        ttl_ok;

    // payload delay matching the checksum pipe
    t_pay        r2_pay, r3_pay, r4_pay;

    logic        csum_valid;
    logic [15:0] csum_out;
    t_csum_ctl   csum_ctl;

    // no back-pressure from inside; only reset holds off new words
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // mask arrives in memory order: exchange bytes before the ident merges; the prefix match uses it as is
    assign mswap  = {i_entry_mask[7:0], i_entry_mask[15:8]};
    assign ttl_ok = i_ttl > i_ttl_limit;

    always_comb begin
        n1_pay.src = i_src_addr;
        n1_pay.dst = i_dst_addr;
        n1_pay.id  = i_ident;
        n1_pay.fr  = i_frag_word;
        n1_pay.did = 1'b0;
        n1_en      = '0;
        case (t_op'(i_operation))
            OP_ENCAP: begin
                n1_pay.did = 1'b1;
                n1_en.dst  = 1'b1;
                n1_pay.dst = i_target_addr;
                if (ttl_ok && i_override_frag) begin
                    // original destination tucked into ident/frag words
                    n1_pay.id = i_dst_addr[31:16];
                    n1_pay.fr = i_dst_addr[15:0];
                    n1_en.id  = 1'b1;
                    n1_en.fr  = 1'b1;
                end else if (ttl_ok) begin
                    n1_pay.id  = (i_src_addr[15:0] & mswap) | (i_ident & ~mswap);
                    n1_pay.src = i_dst_addr;
                    n1_en.id   = 1'b1;
                    n1_en.src  = 1'b1;
                end
            end
            OP_DECAP: begin
                if (i_override_frag) begin
                    // restore destination only when the source prefix matches
                    if ((i_src_addr & i_entry_mask) == i_target_addr) begin
                        n1_pay.did = 1'b1;
                        n1_pay.dst = {i_ident, i_frag_word};
                        n1_pay.id  = 16'd0;
                        n1_pay.fr  = 16'd0;
                        n1_en.dst  = 1'b1;
                        n1_en.id   = 1'b1;
                        n1_en.fr   = 1'b1;
                    end
                end else begin
                    n1_pay.did = 1'b1;
                    n1_pay.dst = i_src_addr;
                    n1_pay.src = i_target_addr | {16'd0, i_ident & mswap};
                    n1_en.dst  = 1'b1;
                    n1_en.src  = 1'b1;
                end
            end
            OP_SWAP: begin
                if (ttl_ok) begin
                    n1_pay.did = 1'b1;
                    n1_pay.dst = i_target_addr;
                    n1_en.dst  = 1'b1;
                end
            end
            default: begin
                // no match: header passes untouched
                n1_pay.did = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_pay     <= n1_pay;
        r1_en      <= n1_en;
        r1_old_src <= i_src_addr;
        r1_old_dst <= i_dst_addr;
        r1_old_id  <= i_ident;
        r1_old_fr  <= i_frag_word;
        r1_csum    <= i_hdr_checksum;
        r2_pay     <= r1_pay;
        r3_pay     <= r2_pay;
        r4_pay     <= r3_pay;
    end

    assign csum_ctl.valid = r1_valid;
    assign csum_ctl.did   = r1_pay.did;

    iparc_csum u_csum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (csum_ctl),
        .i_en       (r1_en),
        .i_old_src  (r1_old_src),
        .i_new_src  (r1_pay.src),
        .i_old_dst  (r1_old_dst),
        .i_new_dst  (r1_pay.dst),
        .i_old_id   (r1_old_id),
        .i_new_id   (r1_pay.id),
        .i_old_fr   (r1_old_fr),
        .i_new_fr   (r1_pay.fr),
        .i_csum     (r1_csum),
        .o_valid    (csum_valid),
        .o_checksum (csum_out)
    );

    assign o_valid         = csum_valid;
    assign o_new_src_addr  = r4_pay.src;
    assign o_new_dst_addr  = r4_pay.dst;
    assign o_new_ident     = r4_pay.id;
    assign o_new_frag_word = r4_pay.fr;
    assign o_new_checksum  = csum_out;
    assign o_changed       = r4_pay.did;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(accept, 4))
        else $error("result strobe does not follow accepted word");
    a_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_operation, 4) == OP_NONE)) |-> !o_changed)
        else $error("no-match word reported as changed");
    a_unchanged_csum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_changed) |-> (o_new_checksum == $past(i_hdr_checksum, 4)))
        else $error("unchanged word carries a new checksum");
    a_swap_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_operation, 4) == OP_SWAP)) |->
        (o_new_src_addr == $past(i_src_addr, 4)))
        else $error("swap mode touched the source address");

endmodule
